// ===== rtl/core/assert_macros.svh =====
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is high
`define ASSERT_CLK_RST(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion, also checked during reset
`define ASSERT_CLK(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/amls_pkg.sv =====
package amls_pkg;

  typedef enum logic [3:0] {
    STEP_QUIT_AP  = 4'd0,
    STEP_JOIN_AP  = 4'd1,
    STEP_CHECK_AP = 4'd2,
    STEP_MODE     = 4'd3,
    STEP_START    = 4'd4,
    STEP_SEND     = 4'd5,
    STEP_DATA     = 4'd6,
    STEP_REQUEST  = 4'd7,
    STEP_CW_MODE  = 4'd8,
    STEP_RESTART  = 4'd9,
    STEP_ESCAPE   = 4'd10
  } step_t;

  typedef enum logic [2:0] {
    LINK_DISC    = 3'd0,
    LINK_CONN    = 3'd1,
    LINK_RIGHT   = 3'd2,
    LINK_MODE    = 3'd3,
    LINK_STARTED = 3'd4,
    LINK_SENDING = 3'd5
  } link_t;

  typedef enum logic [1:0] {
    REQ_NONE   = 2'd0,
    REQ_PARAMS = 2'd1,
    REQ_DATA   = 2'd2,
    REQ_APPLY  = 2'd3
  } host_req_t;

  localparam logic [3:0] MSG_ESCAPE_LE = 4'd11;
  localparam logic [3:0] MSG_NONE      = 4'd0;
  localparam logic [7:0] FAIL_MAX      = 8'd255;
  localparam logic [7:0] FAIL_LIMIT_RESET = 8'd10;
  localparam logic [6:0] SHORT_LENGTH  = 7'd2;

  localparam int S_DATA_W = 24;
  localparam int M_DATA_W = 24;

endpackage

// ===== rtl/core/at_modem_link_sequencer_unit.sv =====
// AT link sequencer: takes one transaction per clock (send tick or classified
// response) while s_tready is high and returns exactly one result per transaction
// from a result register; a skid register behind it keeps the input side open for one
// more transaction while the output is stalled, so the sustained rate is one item
// per cycle while the output is not stalled. Configuration writes of fail_limit are
// taken at any edge with cfg_we.
module at_modem_link_sequencer_unit
  import amls_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_wdata,
  input  logic                s_tvalid,
  output logic                s_tready,
  // response_length[6:0], has_line_end, has_ok, has_busy, has_already_connected,
  // has_error_or_fail, has_network_name, has_query_echo, host_frame,
  // host_request[1:0], zero fill
  input  logic [S_DATA_W-1:0] s_tdata,
  // command
  input  logic [0:0]          s_tuser,
  output logic                m_tvalid,
  input  logic                m_tready,
  // send_valid, send_message[3:0], link_state[2:0], busy_now, failures[7:0],
  // apply_parameters, zero fill
  output logic [M_DATA_W-1:0] m_tdata
);

  logic [7:0] fail_limit;
  step_t      step, step_next;
  link_t      link, link_next;
  logic       busy, busy_next;
  logic [7:0] fails, fails_next;
  logic       toggle, toggle_next;

  logic                out_valid, skid_valid;
  logic [M_DATA_W-1:0] out_data, skid_data;

  logic                s_accept, m_accept;
  logic                send_valid, apply;
  logic [3:0]          send_msg;
  logic [M_DATA_W-1:0] result;

  logic       cmd_resp;
  logic [6:0] resp_len;
  logic       has_le, has_ok, has_busy, has_already, has_err, has_net, has_echo;
  logic       host_frame;
  host_req_t  host_req;
  logic [7:0] fails_inc;

  assign cmd_resp    = s_tuser[0];
  assign resp_len    = s_tdata[6:0];
  assign has_le      = s_tdata[7];
  assign has_ok      = s_tdata[8];
  assign has_busy    = s_tdata[9];
  assign has_already = s_tdata[10];
  assign has_err     = s_tdata[11];
  assign has_net     = s_tdata[12];
  assign has_echo    = s_tdata[13];
  assign host_frame  = s_tdata[14];
  assign host_req    = host_req_t'(s_tdata[16:15]);

  assign s_tready = !skid_valid;
  assign s_accept = s_tvalid && s_tready;
  assign m_accept = out_valid && m_tready;
  assign fails_inc = (fails == FAIL_MAX) ? fails : fails + 8'd1;

  // next state
  always_comb begin
    step_next   = step;
    link_next   = link;
    busy_next   = busy;
    fails_next  = fails;
    toggle_next = toggle;
    if (!cmd_resp) begin
      if (!busy) begin
        if (step == STEP_ESCAPE) begin
          toggle_next = !toggle;
        end else if (step == STEP_RESTART) begin
          fails_next = '0;
        end
      end
    end else if (resp_len > SHORT_LENGTH) begin
      if (has_le) begin
        priority if (has_ok) begin
          unique case (step)
            STEP_MODE: begin
              busy_next = 1'b0; link_next = LINK_MODE; step_next = STEP_START;
            end
            STEP_START: begin
              busy_next = 1'b0; link_next = LINK_STARTED; step_next = STEP_SEND;
            end
            STEP_QUIT_AP: begin
              busy_next = 1'b0; link_next = LINK_DISC; step_next = STEP_JOIN_AP;
            end
            STEP_CW_MODE: begin
              busy_next = 1'b0; link_next = LINK_DISC; step_next = STEP_RESTART;
            end
            STEP_JOIN_AP: begin
              busy_next = 1'b0; link_next = LINK_CONN; step_next = STEP_CHECK_AP;
            end
            STEP_CHECK_AP: begin
              if (has_net) begin
                link_next = LINK_RIGHT; step_next = STEP_MODE;
              end else begin
                busy_next = 1'b0; link_next = LINK_DISC; step_next = STEP_QUIT_AP;
              end
            end
            STEP_SEND: begin
              busy_next = 1'b0; link_next = LINK_SENDING; step_next = STEP_DATA;
            end
            default: begin
            end
          endcase
        end else if (has_busy) begin
          busy_next = 1'b1;
        end else if (step == STEP_START && has_already) begin
          busy_next = 1'b0; link_next = LINK_STARTED; step_next = STEP_SEND;
        end else if (has_err) begin
          busy_next  = 1'b0;
          fails_next = fails_inc;
          link_next  = LINK_DISC;
          step_next  = (fails_inc >= fail_limit) ? STEP_CW_MODE : STEP_QUIT_AP;
        end else if (step == STEP_CHECK_AP && has_echo) begin
          if (has_net) begin
            link_next = LINK_RIGHT; step_next = STEP_MODE;
          end else begin
            busy_next = 1'b0; link_next = LINK_DISC; step_next = STEP_QUIT_AP;
          end
        end else begin
        end
      end else if (host_frame) begin
        unique case (host_req)
          REQ_PARAMS: step_next = STEP_REQUEST;
          REQ_DATA:   step_next = STEP_DATA;
          default: begin
          end
        endcase
      end
    end
  end

  // result of the transaction
  always_comb begin
    send_valid = 1'b0;
    send_msg   = MSG_NONE;
    apply      = 1'b0;
    if (!cmd_resp) begin
      if (!busy) begin
        send_valid = 1'b1;
        if (step == STEP_ESCAPE) begin
          send_msg = toggle ? MSG_ESCAPE_LE : 4'(STEP_ESCAPE);
        end else begin
          send_msg = 4'(step);
        end
      end
    end else if (resp_len > SHORT_LENGTH && !has_le && host_frame) begin
      apply = (host_req == REQ_APPLY);
    end
    result = {6'd0, apply, fails_next, busy_next, 3'(link_next), send_msg, send_valid};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fail_limit <= FAIL_LIMIT_RESET;
    end else if (cfg_we) begin
      fail_limit <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step   <= STEP_ESCAPE;
      link   <= LINK_SENDING;
      busy   <= 1'b0;
      fails  <= '0;
      toggle <= 1'b0;
    end else if (s_accept) begin
      step   <= step_next;
      link   <= link_next;
      busy   <= busy_next;
      fails  <= fails_next;
      toggle <= toggle_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (m_accept) begin
      if (skid_valid) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end else if (s_accept) begin
        out_data <= result;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (s_accept) begin
      if (!out_valid) begin
        out_data  <= result;
        out_valid <= 1'b1;
      end else begin
        skid_data  <= result;
        skid_valid <= 1'b1;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

endmodule

// ===== rtl/core/amls_checker.sv =====
`include "assert_macros.svh"

module amls_checker
  import amls_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                s_tready,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [M_DATA_W-1:0] m_tdata
);

  `ASSERT_CLK(no_result_after_reset, clk, $past(rst) |-> !m_tvalid,
              "result shown after reset")
  `ASSERT_CLK_RST(stall_holds, clk, rst,
                  m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata),
                  "stalled result changed")
  `ASSERT_CLK_RST(idle_msg_zero, clk, rst, m_tvalid && !m_tdata[0] |-> m_tdata[4:1] == 4'd0,
                  "message code without send")
  `ASSERT_CLK_RST(send_not_busy, clk, rst,
                  m_tvalid && m_tdata[0] |-> !m_tdata[8] && !m_tdata[17],
                  "send while busy or with apply strobe")
  `ASSERT_CLK_RST(full_only_when_shown, clk, rst, !s_tready |-> m_tvalid,
                  "input held without a pending result")

endmodule

bind at_modem_link_sequencer_unit amls_checker u_amls_checker (
  .clk(clk),
  .rst(rst),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata(m_tdata)
);

// ===== bench/at_modem_link_sequencer_unit_tb.sv =====
module at_modem_link_sequencer_unit_tb
  import amls_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1000000;

  // response fields from the top bit down, command on top
  typedef struct packed {
    logic      command;
    host_req_t req;
    logic      host;
    logic      echo;
    logic      netname;
    logic      errfail;
    logic      already;
    logic      busy;
    logic      ok;
    logic      line_end;
    logic [6:0] length;
  } link_item_t;

  typedef struct packed {
    logic       apply;
    logic [7:0] failures;
    logic       busy_now;
    link_t      link;
    logic [3:0] message;
    logic       send_valid;
  } link_result_t;

  class link_scoreboard;
    step_t        step;
    link_t        link;
    logic         modem_busy;
    logic [7:0]   fail_count;
    logic         escape_toggle;
    logic [7:0]   fail_limit;
    link_result_t link_results_due[$];
    int           mismatches;

    function new();
      step = STEP_ESCAPE;
      link = LINK_SENDING;
      modem_busy = 1'b0;
      fail_count = '0;
      escape_toggle = 1'b0;
      fail_limit = FAIL_LIMIT_RESET;
      mismatches = 0;
    endfunction

    function void set_position(link_t l, step_t s);
      link = l;
      step = s;
    endfunction

    function void judge_network(logic right);
      if (right) begin
        set_position(LINK_RIGHT, STEP_MODE);
      end else begin
        modem_busy = 1'b0;
        set_position(LINK_DISC, STEP_QUIT_AP);
      end
    endfunction

    function link_result_t next_result(link_item_t it);
      link_result_t r;
      r = '0;
      if (!it.command) begin
        if (!modem_busy) begin
          r.send_valid = 1'b1;
          r.message = step;
          if (step == STEP_ESCAPE) begin
            r.message = escape_toggle ? MSG_ESCAPE_LE : 4'(STEP_ESCAPE);
            escape_toggle = ~escape_toggle;
          end else if (step == STEP_RESTART) begin
            fail_count = '0;
          end
        end
      end else if (it.length > SHORT_LENGTH) begin
        if (it.line_end) begin
          if (it.ok) begin
            case (step)
              STEP_MODE: begin
                modem_busy = 1'b0;
                set_position(LINK_MODE, STEP_START);
              end
              STEP_START: begin
                modem_busy = 1'b0;
                set_position(LINK_STARTED, STEP_SEND);
              end
              STEP_QUIT_AP: begin
                modem_busy = 1'b0;
                set_position(LINK_DISC, STEP_JOIN_AP);
              end
              STEP_CW_MODE: begin
                modem_busy = 1'b0;
                set_position(LINK_DISC, STEP_RESTART);
              end
              STEP_JOIN_AP: begin
                modem_busy = 1'b0;
                set_position(LINK_CONN, STEP_CHECK_AP);
              end
              STEP_CHECK_AP: judge_network(it.netname);
              STEP_SEND: begin
                modem_busy = 1'b0;
                set_position(LINK_SENDING, STEP_DATA);
              end
              default: ;
            endcase
          end else if (it.busy) begin
            modem_busy = 1'b1;
          end else if (step == STEP_START && it.already) begin
            modem_busy = 1'b0;
            set_position(LINK_STARTED, STEP_SEND);
          end else if (it.errfail) begin
            modem_busy = 1'b0;
            if (fail_count != FAIL_MAX) fail_count++;
            if (fail_count >= fail_limit) set_position(LINK_DISC, STEP_CW_MODE);
            else set_position(LINK_DISC, STEP_QUIT_AP);
          end else if (step == STEP_CHECK_AP && it.echo) begin
            judge_network(it.netname);
          end
        end else if (it.host) begin
          case (it.req)
            REQ_PARAMS: step = STEP_REQUEST;
            REQ_DATA:   step = STEP_DATA;
            REQ_APPLY:  r.apply = 1'b1;
            default: ;
          endcase
        end
      end
      r.link = link;
      r.busy_now = modem_busy;
      r.failures = fail_count;
      return r;
    endfunction

    function void note_item(link_item_t it);
      link_results_due.push_back(next_result(it));
    endfunction

    function void check_result(link_result_t got);
      link_result_t exp;
      if (link_results_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result transaction with nothing pending: %h", $realtime, got);
        return;
      end
      exp = link_results_due.pop_front();
      if (got.send_valid !== exp.send_valid || got.message !== exp.message ||
          got.link !== exp.link || got.busy_now !== exp.busy_now ||
          got.failures !== exp.failures || got.apply !== exp.apply) begin
        mismatches++;
        if (mismatches <= 10) begin
          $write("%0t: mismatch exp valid=%0d msg=%0d link=%0d busy=%0d fail=%0d apply=%0d, ",
                 $realtime, exp.send_valid, exp.message, exp.link, exp.busy_now,
                 exp.failures, exp.apply);
          $display("got valid=%0d msg=%0d link=%0d busy=%0d fail=%0d apply=%0d",
                   got.send_valid, got.message, got.link, got.busy_now, got.failures,
                   got.apply);
        end
      end
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                cfg_we;
  logic [7:0]          cfg_wdata;
  logic                s_tvalid;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata;
  logic [0:0]          s_tuser;
  logic                m_tvalid;
  logic                m_tready;
  logic [M_DATA_W-1:0] m_tdata;

  link_scoreboard sb = new();
  bit idle_enable;
  int sink_hold;
  int cycle_count;

  at_modem_link_sequencer_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #6 clk = ~clk;

  function automatic int idle_length();
    return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
  endfunction

  function automatic link_item_t tick_item();
    link_item_t it;
    it = link_item_t'(18'($urandom));
    it.command = 1'b0;
    it.length = 7'($urandom_range(0, 80));
    return it;
  endfunction

  function automatic link_item_t line_item(logic [6:0] len);
    link_item_t it;
    it = '0;
    it.command = 1'b1;
    it.line_end = 1'b1;
    it.length = len;
    return it;
  endfunction

  // send ticks and mostly well-formed responses with random content, some noise
  function automatic link_item_t random_item();
    link_item_t it;
    int kind;
    kind = $urandom_range(0, 99);
    it = link_item_t'(18'($urandom));
    it.command = 1'b1;
    it.line_end = 1'b1;
    it.length = 7'($urandom_range(3, 80));
    if (kind < 40) begin
      it = tick_item();
    end else if (kind < 60) begin
      it.ok = 1'b1;
      it.netname = ($urandom_range(0, 9) < 7);
    end else if (kind < 66) begin
      it.ok = 1'b0;
      it.busy = 1'b1;
    end else if (kind < 72) begin
      it.ok = 1'b0;
      it.busy = 1'b0;
      it.already = 1'b1;
    end else if (kind < 80) begin
      it.ok = 1'b0;
      it.busy = 1'b0;
      it.errfail = 1'b1;
    end else if (kind < 86) begin
      it.ok = 1'b0;
      it.busy = 1'b0;
      it.already = 1'b0;
      it.errfail = 1'b0;
      it.echo = 1'b1;
    end else if (kind < 94) begin
      it.line_end = 1'b0;
      it.host = ($urandom_range(0, 9) != 0);
    end else begin
      it.length = ($urandom_range(0, 9) < 3) ? 7'($urandom_range(0, 2))
                                             : 7'($urandom_range(0, 80));
    end
    return it;
  endfunction

  task automatic send_item(link_item_t it);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata <= {{(S_DATA_W - 17){1'b0}}, it[16:0]};
    s_tuser <= it.command;
    do @(posedge clk); while (!s_tready);
    sb.note_item(it);
    gap = (idle_enable && $urandom_range(0, 1)) ? idle_length() : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic run_random(int count);
    for (int i = 0; i < count; i++) begin
      if (i % 64 == 0) idle_enable = ($urandom_range(0, 3) != 0);
      send_item(random_item());
    end
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (sb.link_results_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_fail_limit(logic [7:0] value);
    drain_results();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.fail_limit = value;
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // result side with random stalls
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata[17:0]);
    if (sink_hold != 0) begin
      sink_hold--;
    end else if (idle_enable && $urandom_range(0, 3) == 0) begin
      m_tready <= 1'b0;
      sink_hold = idle_length() - 1;
    end else begin
      m_tready <= 1'b1;
      sink_hold = $urandom_range(0, 5);
    end
  end

  initial begin
    link_item_t it;
    clk = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    m_tready = 1'b0;
    idle_enable = 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // escape toggling, ignored responses, then the setup chain
    repeat (3) send_item(tick_item());
    it = line_item(7'd3);
    it.ok = 1'b1;
    send_item(it);
    it = '1;
    it.length = 7'd2;
    send_item(it);
    it = line_item(7'd0);
    it.errfail = 1'b1;
    send_item(it);
    it = line_item(7'd80);
    it.errfail = 1'b1;
    send_item(it);
    send_item(tick_item());
    it = line_item(7'd3);
    it.ok = 1'b1;
    send_item(it);
    send_item(tick_item());
    send_item(it);
    it = line_item(7'd40);
    it.busy = 1'b1;
    send_item(it);
    send_item(tick_item());
    it = line_item(7'd12);
    it.ok = 1'b1;
    it.netname = 1'b1;
    send_item(it);
    send_item(tick_item());
    it.netname = 1'b0;
    send_item(it);
    it = line_item(7'd9);
    it.already = 1'b1;
    send_item(it);
    it = line_item(7'd9);
    it.ok = 1'b1;
    send_item(it);
    send_item(tick_item());
    send_item(it);
    it = '0;
    it.command = 1'b1;
    it.length = 7'd80;
    it.host = 1'b1;
    it.req = REQ_PARAMS;
    send_item(it);
    send_item(tick_item());
    it.req = REQ_APPLY;
    send_item(it);
    it.req = REQ_NONE;
    send_item(it);
    it.host = 1'b0;
    it.req = REQ_DATA;
    send_item(it);
    it.host = 1'b1;
    send_item(it);
    run_random(380);

    // limit of one: fall back to station mode and restart
    write_fail_limit(8'd1);
    it = line_item(7'd5);
    it.errfail = 1'b1;
    send_item(it);
    send_item(tick_item());
    it = line_item(7'd5);
    it.ok = 1'b1;
    send_item(it);
    send_item(tick_item());
    run_random(300);

    // highest limit with the failure count driven into saturation
    write_fail_limit(8'd255);
    it = line_item(7'd6);
    it.errfail = 1'b1;
    it.echo = 1'b1;
    repeat (260) send_item(it);
    send_item(tick_item());
    it = line_item(7'd6);
    it.ok = 1'b1;
    send_item(it);
    repeat (2) send_item(tick_item());
    run_random(250);

    write_fail_limit(8'd0);
    run_random(250);

    write_fail_limit(8'($urandom_range(2, 20)));
    run_random(200);

    drain_results();
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0 && sb.link_results_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
